// ===== rtl/core/unsharp_mask_gauss5x5_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the unsharp mask block
// Shared helpers so that every checking module reports the same way.
// ----------------------------------------------------------------------------
`ifndef UNSHARP_MASK_GAUSS5X5_DEFINES_SVH
`define UNSHARP_MASK_GAUSS5X5_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UMG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UMG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/umg_pkg.sv =====
// ----------------------------------------------------------------------------
// umg_pkg
// Shared types, register codes and kernel weight functions.
// ----------------------------------------------------------------------------
package umg_pkg;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SHARPEN_GAIN = 2'd2;

  // input item operations
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // effective frame settings
  typedef struct packed {
    logic [13:0] w;
    logic [15:0] h;
    logic [3:0]  gain;
  } umg_cfg_t;

  // one unit of work for the back end
  typedef struct packed {
    logic        wr;
    logic        emit;
    logic        last;
    logic [15:0] pix;
    logic [3:0]  wslot;
    logic [12:0] wcol;
    logic [3:0]  oslot;
    logic [12:0] ocol;
    logic [15:0] orow;
  } umg_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADDR,
    BK_ACC,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  // Q15 Gaussian weight by squared distance
  function automatic logic [15:0] gauss_q15(input logic [4:0] d2);
    case (d2)
      5'd0:    gauss_q15 = 16'd32768;
      5'd1:    gauss_q15 = 16'd23155;
      5'd2:    gauss_q15 = 16'd16363;
      5'd4:    gauss_q15 = 16'd8171;
      5'd5:    gauss_q15 = 16'd5774;
      5'd8:    gauss_q15 = 16'd2037;
      5'd9:    gauss_q15 = 16'd1440;
      5'd10:   gauss_q15 = 16'd1017;
      5'd13:   gauss_q15 = 16'd359;
      5'd18:   gauss_q15 = 16'd63;
      default: gauss_q15 = 16'd0;
    endcase
  endfunction

  function automatic logic [4:0] sq3(input logic [2:0] m);
    case (m)
      3'd0:    sq3 = 5'd0;
      3'd1:    sq3 = 5'd1;
      3'd2:    sq3 = 5'd4;
      3'd3:    sq3 = 5'd9;
      default: sq3 = 5'd16;
    endcase
  endfunction

  // rescale to wb bits, rounding half up when shrinking
  function automatic logic [31:0] weight_of(input logic [4:0] d2, input int wb);
    logic [63:0] t;
    int up;
    int dn;
    t  = 64'(gauss_q15(d2));
    up = (wb > 16) ? wb - 16 : 0;
    dn = (wb < 16) ? 16 - wb : 0;
    t  = ((t << (up + 1)) + (64'd1 << dn)) >> (dn + 1);
    return t[31:0];
  endfunction

endpackage

// ===== rtl/core/umg_if.sv =====
// ----------------------------------------------------------------------------
// umg channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface umg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] pixel_in;
  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface umg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        last_of_frame;
  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// ===== rtl/core/umg_front.sv =====
// ----------------------------------------------------------------------------
// umg_front
// Accepts items, tracks frame positions and queues store/emit work.
// ----------------------------------------------------------------------------
module umg_front #(
  parameter int MAX_WIDTH     = 4096,
  parameter int KERNEL_RADIUS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  umg_in_if.sink             in_s,
  input  umg_pkg::umg_cfg_t  cfg,
  input  logic               q_full,
  output logic               q_push,
  output umg_pkg::umg_entry_t q_entry
);
  import umg_pkg::*;

  localparam int LS_ROWS = 3 * KERNEL_RADIUS + 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int SLW     = $clog2(LS_ROWS);
  localparam int PW      = $clog2(KERNEL_RADIUS * MAX_WIDTH + KERNEL_RADIUS + 2);

  logic [CW-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0]    in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SLW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0]  pend_r, pend_nxt, pend_inc, delay;
  logic           acc, is_pix, emit, in_wrap, out_wrap;
  logic [CW:0]    in_col_inc, out_col_inc;
  logic [16:0]    in_row_inc, out_row_inc;

  assign in_s.ready = !q_full;
  assign acc        = in_s.valid && !q_full;
  assign is_pix     = (in_s.operation == OP_PIXEL);
  assign delay      = PW'(cfg.w) * PW'(KERNEL_RADIUS) + PW'(KERNEL_RADIUS);
  assign pend_inc   = pend_r + 1'b1;

  assign in_col_inc  = (CW + 1)'(in_col_r) + 1'b1;
  assign out_col_inc = (CW + 1)'(out_col_r) + 1'b1;
  assign in_row_inc  = {1'b0, in_row_r} + 1'b1;
  assign out_row_inc = {1'b0, out_row_r} + 1'b1;
  assign in_wrap     = 14'(in_col_inc) >= cfg.w;
  assign out_wrap    = 14'(out_col_inc) >= cfg.w;

  always_comb begin
    if (is_pix) begin
      emit = pend_inc > delay;
    end else begin
      emit = (pend_r != '0) && (in_col_r == '0) && (in_row_r == '0);
    end
  end

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    pend_nxt     = pend_r;
    if (acc && is_pix) begin
      pend_nxt = emit ? pend_r : pend_inc;
      if (in_wrap) begin
        in_col_nxt  = '0;
        in_slot_nxt = (in_slot_r == SLW'(LS_ROWS - 1)) ? '0 : in_slot_r + 1'b1;
        in_row_nxt  = (in_row_inc >= {1'b0, cfg.h}) ? '0 : in_row_inc[15:0];
      end else begin
        in_col_nxt = in_col_inc[CW-1:0];
      end
    end else if (acc && emit) begin
      pend_nxt = pend_r - 1'b1;
    end
    if (acc && emit) begin
      if (out_wrap) begin
        out_col_nxt  = '0;
        out_slot_nxt = (out_slot_r == SLW'(LS_ROWS - 1)) ? '0 : out_slot_r + 1'b1;
        out_row_nxt  = (out_row_inc >= {1'b0, cfg.h}) ? '0 : out_row_inc[15:0];
      end else begin
        out_col_nxt = out_col_inc[CW-1:0];
      end
    end
  end

  always_comb begin
    q_push        = acc && (is_pix || emit);
    q_entry.wr    = is_pix;
    q_entry.emit  = emit;
    q_entry.last  = (14'(out_col_inc) == cfg.w) && (out_row_inc == {1'b0, cfg.h});
    q_entry.pix   = in_s.pixel_in;
    q_entry.wslot = 4'(in_slot_r);
    q_entry.wcol  = 13'(in_col_r);
    q_entry.oslot = 4'(out_slot_r);
    q_entry.ocol  = 13'(out_col_r);
    q_entry.orow  = out_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pend_r     <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

// ===== rtl/core/umg_fifo.sv =====
// ----------------------------------------------------------------------------
// umg_fifo
// Short queue of work entries between front and back ends.
// ----------------------------------------------------------------------------
module umg_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  umg_pkg::umg_entry_t din,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output umg_pkg::umg_entry_t dout
);
  import umg_pkg::*;

  localparam int DEPTH = 4;

  umg_entry_t  mem_r [DEPTH];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r, cnt_nxt;

  assign full      = cnt_r == 3'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign dout      = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/umg_div.sv =====
// ----------------------------------------------------------------------------
// umg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module umg_div #(
  parameter int NW = 40,
  parameter int DW = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  q_r;
  logic [DW:0]    rem_r;
  logic [DW-1:0]  den_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [DW:0]    rem_sh, rem_sub;
  logic           ge;

  assign rem_sh  = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign done    = done_r;
  assign quo     = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub : rem_sh;
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/umg_back.sv =====
// ----------------------------------------------------------------------------
// umg_back
// Line store, tap accumulation, normalization and sharpening.
// ----------------------------------------------------------------------------
module umg_back #(
  parameter int MAX_WIDTH     = 4096,
  parameter int KERNEL_RADIUS = 2,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  umg_pkg::umg_cfg_t   cfg,
  input  logic                q_not_empty,
  input  umg_pkg::umg_entry_t q_entry,
  output logic                q_pop,
  umg_out_if.source           out_s
);
  import umg_pkg::*;
  `include "unsharp_mask_gauss5x5_defines.svh"

  localparam int LS_ROWS  = 3 * KERNEL_RADIUS + 1;
  localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
  localparam int AW       = $clog2(LS_DEPTH);
  localparam int WW       = WEIGHT_BITS;
  localparam int SW       = WW + 22;
  localparam int NWD      = WW + 6;
  localparam int DNW      = SW + 2;
  localparam int DDW      = NWD + 1;

  localparam logic [2:0] KR = 3'(KERNEL_RADIUS);
  localparam logic [2:0] KD = 3'(2 * KERNEL_RADIUS);

  logic [15:0]   mem [LS_DEPTH];
  logic [15:0]   rd_q;
  logic [AW-1:0] wr_addr, rd_addr;

  bk_state_t     st_r, st_nxt;
  umg_entry_t    ent_r;
  logic [2:0]    tx_r, ty_r;
  logic [SW-1:0] sum_r, sum_add;
  logic [NWD-1:0] n_r, n_add;
  logic [15:0]   center_r;
  logic [16:0]   lp_r;
  logic [WW-1:0] tw_r;
  logic          tc_r;
  logic          ov_r;
  logic [15:0]   opix_r;
  logic          olast_r;

  logic          mwe, div_start, load_out, last_tap;
  logic          div_done;
  logic [DNW-1:0] div_quo;

  // tap geometry
  logic [2:0]  mag_x, mag_y;
  logic [4:0]  d2, slot_s;
  logic [17:0] row_t;
  logic [14:0] col_t;
  logic        tap_ok;
  logic [AW-1:0] tap_slot_base;

  // result
  logic signed [17:0] diff;
  logic signed [22:0] prod;
  logic signed [23:0] res;
  logic [15:0]        res_c;

  assign mag_x  = (tx_r >= KR) ? tx_r - KR : KR - tx_r;
  assign mag_y  = (ty_r >= KR) ? ty_r - KR : KR - ty_r;
  assign d2     = sq3(mag_x) + sq3(mag_y);
  assign row_t  = {2'b00, ent_r.orow} + 18'(ty_r) - 18'(KR);
  assign col_t  = {2'b00, ent_r.ocol} + 15'(tx_r) - 15'(KR);
  assign tap_ok = !row_t[17] && (row_t < {2'b00, cfg.h}) &&
                  !col_t[14] && (col_t[13:0] < cfg.w);

  always_comb begin
    slot_s = 5'(ent_r.oslot) + 5'(ty_r) + 5'(2 * KERNEL_RADIUS + 1);
    if (slot_s >= 5'(2 * LS_ROWS)) begin
      slot_s = slot_s - 5'(2 * LS_ROWS);
    end else if (slot_s >= 5'(LS_ROWS)) begin
      slot_s = slot_s - 5'(LS_ROWS);
    end
  end

  assign tap_slot_base = AW'(slot_s) * AW'(MAX_WIDTH);
  assign rd_addr       = tap_slot_base + AW'(col_t[13:0]);
  assign wr_addr       = AW'(q_entry.wslot) * AW'(MAX_WIDTH) + AW'(q_entry.wcol);

  assign last_tap = (tx_r == KD) && (ty_r == KD);
  // skipped taps carry no weight; keep their store data out of the sum
  assign sum_add  = sum_r + ((tw_r == '0) ? SW'(0) : SW'(tw_r * rd_q));
  assign n_add    = n_r + NWD'(tw_r);

  // line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[wr_addr] <= q_entry.pix;
    end
    rd_q <= mem[rd_addr];
  end

  umg_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sum_add, 1'b0} + DNW'(n_add)),
    .den   ({n_add, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign diff  = $signed({2'b00, center_r}) - $signed({1'b0, lp_r});
  assign prod  = $signed({1'b0, cfg.gain}) * diff;
  assign res   = 24'(prod) + $signed({8'd0, center_r});
  assign res_c = res[23] ? 16'd0 : ((res > 24'sd65535) ? 16'hFFFF : res[15:0]);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_not_empty && q_entry.emit) st_nxt = BK_ADDR;
      BK_ADDR: st_nxt = BK_ACC;
      BK_ACC: begin
        if (!last_tap) begin
          st_nxt = BK_ADDR;
        end else if (n_add == '0) begin
          st_nxt = BK_FIN;
        end else begin
          st_nxt = BK_DIV;
        end
      end
      BK_DIV: if (div_done) st_nxt = BK_FIN;
      BK_FIN: if (!ov_r || out_s.ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    mwe       = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (st_r)
      BK_IDLE: begin
        q_pop = q_not_empty;
        mwe   = q_not_empty && q_entry.wr;
      end
      BK_ACC:  div_start = last_tap && (n_add != '0);
      BK_FIN:  load_out = !ov_r || out_s.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        ent_r    <= q_entry;
        tx_r     <= '0;
        ty_r     <= '0;
        sum_r    <= '0;
        n_r      <= '0;
        center_r <= '0;
        lp_r     <= '0;
      end
      BK_ADDR: begin
        tw_r <= tap_ok ? WW'(weight_of(d2, WW)) : '0;
        tc_r <= tap_ok && (tx_r == KR) && (ty_r == KR);
      end
      BK_ACC: begin
        sum_r <= sum_add;
        n_r   <= n_add;
        if (tc_r) center_r <= rd_q;
        if (tx_r == KD) begin
          tx_r <= '0;
          ty_r <= ty_r + 1'b1;
        end else begin
          tx_r <= tx_r + 1'b1;
        end
      end
      BK_DIV: if (div_done) lp_r <= div_quo[16:0];
      default: ;
    endcase
    if (load_out) begin
      opix_r  <= res_c;
      olast_r <= ent_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_s.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_s.valid         = ov_r;
  assign out_s.pixel_out     = opix_r;
  assign out_s.last_of_frame = olast_r;

  `UMG_ASSERT_IMP(a_div_den_nonzero, div_start, n_add != '0, "divider started with zero weight")
  `UMG_ASSERT_IMP(a_pop_only_idle, q_pop, st_r == BK_IDLE, "queue popped while busy")
  `UMG_ASSERT_NXT(a_div_stays, (st_r == BK_DIV) && !div_done, st_r == BK_DIV, "left divide early")

endmodule

// ===== rtl/core/unsharp_mask_gauss5x5.sv =====
// Streaming unsharp mask with a 5x5 Gaussian low-pass. Pixels enter in raster
// order on in_s (operation 0 = pixel, 1 = flush tick) and each result leaves
// on out_s R*W+R positions after its own pixel; flush ticks at the start of a
// frame drain the last rows. A pixel that only fills the line store is written
// as the back end pops it while idle; a pixel that also yields a result has its
// taps fetched one at a time through the single read port of the line store,
// and the normalizing divide takes one quotient bit per cycle. A four-entry
// queue parts front and back, so intake runs ahead while the back end works.
// The line store needs no clearing pass after reset. Registers: image_width at
// 0x0, image_height at 0x4, sharpen_gain at 0x8; write only while the block is
// idle.
// ----------------------------------------------------------------------------
// unsharp_mask_gauss5x5
// Top level: register port, front end, work queue and back end.
// ----------------------------------------------------------------------------
module unsharp_mask_gauss5x5 #(
  parameter int MAX_WIDTH     = 4096,
  parameter int KERNEL_RADIUS = 2,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  umg_in_if.sink      in_s,
  umg_out_if.source   out_s,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import umg_pkg::*;

  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [3:0]  gain_r;
  logic        wr_en;
  umg_cfg_t    cfg;

  logic       q_full, q_push, q_pop, q_not_empty;
  umg_entry_t q_in, q_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd4096;
      height_r <= 16'd4096;
      gain_r   <= 4'd2;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  width_r  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[15:0];
        REG_SHARPEN_GAIN: gain_r   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = {19'd0, width_r};
      REG_IMAGE_HEIGHT: prdata = {16'd0, height_r};
      REG_SHARPEN_GAIN: prdata = {28'd0, gain_r};
      default:          prdata = '0;
    endcase
  end

  // zero width or height act as one; clamp width to the line store
  always_comb begin
    if (width_r == '0) begin
      cfg.w = 14'd1;
    end else if (14'(width_r) > 14'(MAX_WIDTH)) begin
      cfg.w = 14'(MAX_WIDTH);
    end else begin
      cfg.w = 14'(width_r);
    end
    cfg.h    = (height_r == '0) ? 16'd1 : height_r;
    cfg.gain = gain_r;
  end

  umg_front #(.MAX_WIDTH(MAX_WIDTH), .KERNEL_RADIUS(KERNEL_RADIUS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_s),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  umg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_out)
  );

  umg_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .KERNEL_RADIUS (KERNEL_RADIUS),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_entry     (q_out),
    .q_pop       (q_pop),
    .out_s       (out_s)
  );

endmodule
